// ===== src/rsi_pkg.sv =====
// Shared definitions for the relative strength index block.
// Holds the default sizes, the result constants and the adder op codes.
// No dependencies.
`default_nettype none

package rsi_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned PERIOD_DEF      = 14;
  localparam int unsigned PRICE_WIDTH_DEF = 32;

  // Stream field widths
  localparam int unsigned PRICE_TDATA_W = 32;
  localparam int unsigned RSI_W         = 14;
  localparam int unsigned OUT_TDATA_W   = 16;

  // Result codes
  localparam logic [RSI_W-1:0] RSI_HALF = 14'd5000;
  localparam logic [RSI_W-1:0] RSI_FULL = 14'd10000;

  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
  localparam int unsigned SCALE_TOP_SHIFT = 13;
  localparam int unsigned SCALE_SHIFT [4] = '{10, 9, 8, 4};

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

`default_nettype wire

// ===== src/rsi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the price window. No dependencies.
`default_nettype none

module rsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 14
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rsi_alu.sv =====
// Shared adder/subtractor used for every sum, scaling and divide step of the block.
// Depends on rsi_pkg for the op codes.
`default_nettype none

module rsi_alu #(
  parameter int unsigned W = 50
) (
  input  wire logic [W-1:0]          a,
  input  wire logic [W-1:0]          b,
  input  wire rsi_pkg::alu_op_t      op,
  output logic      [W-1:0]          res,
  output logic                       cout
);

  import rsi_pkg::*;

  logic          sub;
  logic [W:0]    sum;

  // On subtract, cout high means a >= b (no borrow)
  assign sub        = (op == ALU_SUB);
  assign sum        = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
  assign res        = sum[W-1:0];
  assign cout       = sum[W];

endmodule

`default_nettype wire

// ===== src/relative_strength_index.sv =====
// Top level of the relative strength index block: stream ports, sequencer,
// window pointers, sums and the shift-subtract divider around one shared adder.
// Depends on rsi_pkg, rsi_ram and rsi_alu.
`default_nettype none

// Takes one price per input transfer (tdata) with a restart flag (tuser) and
// returns one result per transfer: RSI in hundredths over the last PERIOD
// prices (tdata) and a ready flag (tuser). The input is held off while an
// item is worked on; the sum, scaling and divide arithmetic goes through one
// adder under a small sequencer. The first sample after reset or restart goes
// from acceptance to the window write and the result load; while the window
// fills, the new step is added to the sums first; when the window is full the
// window reads (S_RD0, S_RD1) and the removal of the oldest step come before
// that. Where the window is full and losses are held, the window write is
// followed by the denominator, the x10000 scaling, the restoring divide and
// the result load. The sample that first fills the window skips the reads and
// the removal. The finished result sits in an output register, so the next
// item is taken while it waits for the consumer; a result that is still
// waiting holds the sequencer in S_FIN until the consumer takes it.
module relative_strength_index #(
  parameter int unsigned PERIOD      = rsi_pkg::PERIOD_DEF,
  parameter int unsigned PRICE_WIDTH = rsi_pkg::PRICE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rsi_pkg::PRICE_TDATA_W-1:0] s_tdata,  // [31:0] price
  input  wire logic [0:0]                        s_tuser,  // [0] restart
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [rsi_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [13:0] rsi_hundredths
  output logic      [0:0]                        m_tuser   // [0] ready_res
);

  import rsi_pkg::*;

  localparam int unsigned IW    = $clog2(PERIOD);
  localparam int unsigned CW    = $clog2(PERIOD + 1);
  localparam int unsigned SUM_W = PRICE_WIDTH + $clog2(PERIOD);
  localparam int unsigned AW    = SUM_W + RSI_W;
  localparam int unsigned SW    = $clog2(RSI_W);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RMD   = 4'd3;
  localparam logic [3:0] S_RMU   = 4'd4;
  localparam logic [3:0] S_ADDD  = 4'd5;
  localparam logic [3:0] S_ADDU  = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_DEN   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  // Control state
  logic [3:0]             state;
  logic [CW-1:0]          cnt;
  logic [IW-1:0]          wp;
  logic [SUM_W-1:0]       gain;
  logic [SUM_W-1:0]       loss;
  logic                   out_valid;

  // Working registers
  logic [PRICE_WIDTH-1:0] price;
  logic [PRICE_WIDTH-1:0] last;
  logic [PRICE_WIDTH-1:0] older;
  logic [SUM_W-1:0]       diff;
  logic                   ge;
  logic [SUM_W-1:0]       den;
  logic [AW-1:0]          acc;
  logic [1:0]             k;
  logic [SUM_W-1:0]       rem;
  logic [RSI_W-1:0]       low;
  logic [SW-1:0]          step;
  logic [RSI_W-1:0]       q;
  logic                   rdy;
  logic [RSI_W-1:0]       out_rsi;
  logic                   out_rdy;

  // Window memory and shared adder hookup
  logic                   ram_we;
  logic [IW-1:0]          ram_raddr;
  logic [PRICE_WIDTH-1:0] ram_rdata;
  logic [AW-1:0]          alu_a;
  logic [AW-1:0]          alu_b;
  alu_op_t                alu_op;
  logic [AW-1:0]          alu_res;
  logic                   alu_cout;

  logic [IW-1:0]          wp_inc;
  logic [CW-1:0]          cnt_inc;
  logic [SUM_W:0]         trial;
  logic                   fin_load;
  logic                   in_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign wp_inc   = (wp == IW'(PERIOD - 1)) ? '0 : wp + 1'b1;
  assign cnt_inc  = (cnt == CW'(PERIOD)) ? cnt : cnt + 1'b1;
  assign trial    = {rem, low[RSI_W-1]};
  assign fin_load = (state == S_FIN) && (!out_valid || m_tready);

  assign ram_we    = (state == S_WRITE);
  assign ram_raddr = (state == S_RD1) ? wp_inc : wp;

  rsi_ram #(
    .WIDTH (PRICE_WIDTH),
    .DEPTH (PERIOD)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (price),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rsi_alu #(
    .W (AW)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .op   (alu_op),
    .res  (alu_res),
    .cout (alu_cout)
  );

  // Adder operand select per sequencer step
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state)
      S_RMD: begin
        alu_a  = AW'(ram_rdata);
        alu_b  = AW'(older);
        alu_op = ALU_SUB;
      end
      S_RMU: begin
        // drop the oldest step: gain -= d, or loss -= |d| == loss + d
        alu_a  = ge ? AW'(gain) : AW'(loss);
        alu_b  = AW'(diff);
        alu_op = ge ? ALU_SUB : ALU_ADD;
      end
      S_ADDD: begin
        alu_a  = AW'(price);
        alu_b  = AW'(last);
        alu_op = ALU_SUB;
      end
      S_ADDU: begin
        // add the new step: gain += d, or loss += |d| == loss - d
        alu_a  = ge ? AW'(gain) : AW'(loss);
        alu_b  = AW'(diff);
        alu_op = ge ? ALU_ADD : ALU_SUB;
      end
      S_DEN: begin
        alu_a = AW'(gain);
        alu_b = AW'(loss);
      end
      S_MUL: begin
        alu_a = acc;
        alu_b = AW'(gain) << SCALE_SHIFT[k];
      end
      S_DIV: begin
        alu_a  = AW'(trial);
        alu_b  = AW'(den);
        alu_op = ALU_SUB;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wp        <= '0;
      gain      <= '0;
      loss      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_tuser[0]) begin
              cnt   <= '0;
              wp    <= '0;
              gain  <= '0;
              loss  <= '0;
              state <= S_WRITE;
            end else if (cnt == CW'(PERIOD)) begin
              state <= S_RD0;
            end else if (cnt != '0) begin
              state <= S_ADDD;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RMD;
        S_RMD:  state <= S_RMU;
        S_RMU: begin
          if (ge) begin
            gain <= alu_res[SUM_W-1:0];
          end else begin
            loss <= alu_res[SUM_W-1:0];
          end
          state <= S_ADDD;
        end
        S_ADDD: state <= S_ADDU;
        S_ADDU: begin
          if (ge) begin
            gain <= alu_res[SUM_W-1:0];
          end else begin
            loss <= alu_res[SUM_W-1:0];
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          wp  <= wp_inc;
          cnt <= cnt_inc;
          if ((cnt_inc == CW'(PERIOD)) && (loss != '0)) begin
            state <= S_DEN;
          end else begin
            state <= S_FIN;
          end
        end
        S_DEN:  state <= S_MUL;
        S_MUL: begin
          if (k == 2'd3) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == SW'(RSI_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      price <= PRICE_WIDTH'(s_tdata);
    end
    if (state == S_RD1) begin
      older <= ram_rdata;
    end
    if ((state == S_RMD) || (state == S_ADDD)) begin
      diff <= alu_res[SUM_W-1:0];
      ge   <= alu_cout;
    end
    if (state == S_WRITE) begin
      last <= price;
      rdy  <= (cnt_inc == CW'(PERIOD));
      if (cnt_inc != CW'(PERIOD)) begin
        q <= RSI_HALF;
      end else begin
        q <= RSI_FULL;
      end
    end
    // Scaling: acc = gain * 10000 by shift-and-add
    if (state == S_DEN) begin
      den <= alu_res[SUM_W-1:0];
      acc <= AW'(gain) << SCALE_TOP_SHIFT;
      k   <= '0;
    end
    if (state == S_MUL) begin
      acc  <= alu_res;
      k    <= k + 1'b1;
      rem  <= alu_res[AW-1 -: SUM_W];
      low  <= alu_res[RSI_W-1:0];
      step <= '0;
    end
    // Restoring divide, one quotient bit per cycle
    if (state == S_DIV) begin
      rem  <= alu_cout ? alu_res[SUM_W-1:0] : trial[SUM_W-1:0];
      low  <= {low[RSI_W-2:0], 1'b0};
      q    <= {q[RSI_W-2:0], alu_cout};
      step <= step + 1'b1;
    end
    if (fin_load) begin
      out_rsi <= q;
      out_rdy <= rdy;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_rsi);
  assign m_tuser  = out_rdy;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(PERIOD))
    else $error("sample count above window size");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below denominator");

  a_not_ready_half: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[RSI_W-1:0] == RSI_HALF))
    else $error("result before window full is not the neutral value");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[RSI_W-1:0] <= RSI_FULL))
    else $error("result above full scale");

endmodule

`default_nettype wire
